// ===== rtl/core/ise_pkg.sv =====
`timescale 1ns / 1ps

package ise_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned ValueW   = 32;

  // One slot of the sorted chain.
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
  } slot_t;

endpackage

// ===== rtl/core/ise_cell.sv =====
`timescale 1ns / 1ps

module ise_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              insert_i,
  input  logic signed [ise_pkg::ValueW-1:0] ins_value_i,
  input  logic                              shift_i,
  input  ise_pkg::slot_t                    prev_i,
  input  logic                              prev_place_i,
  input  ise_pkg::slot_t                    next_i,
  output logic                              place_o,
  output ise_pkg::slot_t                    slot_o
);
  import ise_pkg::*;

  logic                     valid_q, valid_d;
  logic signed [ValueW-1:0] value_q, value_d;

  // Empty slots and slots holding something strictly larger make room.
  assign place_o = !valid_q || (value_q > ins_value_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (insert_i && place_o) begin
      if (prev_place_i) begin
        // Larger run moves up by one.
        valid_d = prev_i.valid;
        value_d = prev_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = ins_value_i;
      end
    end else if (shift_i) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.value = value_q;

endmodule

// ===== rtl/core/insertion_sort_engine_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Beat payload                                  Accepted when
// s_axis    in   tdata[31:0] value, tlast = last               tvalid && tready
// m_axis    out  tdata[31:0] sorted_value, tlast = end_of_set, tvalid && tready
//                tuser[0] = dropped
//
// Load phase: one value is inserted per cycle while tvalid is high; every cell
// compares in parallel. A beat with tlast is inserted, then the set drains from
// cell 0, one beat per cycle while the sink is ready, the chain shifting down on
// each output beat. No input is taken during the drain.
// Reset empties the chain at once.
// Either side may stall freely; stalled state simply holds.

module insertion_sort_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // [0] dropped
);
  import ise_pkg::*;

  localparam logic StLoad  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic state_q, state_d;
  logic overflow_q, overflow_d;

  slot_t               slot     [Capacity];
  slot_t               prev_s   [Capacity];
  slot_t               next_s   [Capacity];
  logic [Capacity-1:0] place;
  logic [Capacity-1:0] prev_pl;
  logic [Capacity-1:0] valid_vec;

  logic in_beat, out_beat, full, insert, shift;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  // Last cell occupied means the chain is full: drop the value.
  assign full     = slot[Capacity-1].valid;
  assign insert   = in_beat && !full;
  assign shift    = out_beat;

  genvar gi;
  generate
    for (gi = 0; gi < Capacity; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign prev_s[gi]  = '0;
        assign prev_pl[gi] = 1'b0;
      end else begin : g_body
        assign prev_s[gi]  = slot[gi-1];
        assign prev_pl[gi] = place[gi-1];
      end
      if (gi == Capacity - 1) begin : g_tail
        assign next_s[gi] = '0;
      end else begin : g_link
        assign next_s[gi] = slot[gi+1];
      end
      assign valid_vec[gi] = slot[gi].valid;

      ise_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .insert_i     (insert),
        .ins_value_i  (s_axis_tdata),
        .shift_i      (shift),
        .prev_i       (prev_s[gi]),
        .prev_place_i (prev_pl[gi]),
        .next_i       (next_s[gi]),
        .place_o      (place[gi]),
        .slot_o       (slot[gi])
      );
    end
  endgenerate

  // End of set: nothing behind cell 0.
  logic tail_empty;
  if (Capacity > 1) begin : g_tail_chk
    assign tail_empty = !slot[1].valid;
  end else begin : g_tail_one
    assign tail_empty = 1'b1;
  end

  always_comb begin
    state_d    = state_q;
    overflow_d = overflow_q;
    case (state_q)
      StLoad: begin
        if (in_beat && full) begin
          overflow_d = 1'b1;
        end
        if (in_beat && s_axis_tlast) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // Leave once the final beat goes out (or nothing is held at all).
        if ((out_beat && tail_empty) || !slot[0].valid) begin
          state_d    = StLoad;
          overflow_d = 1'b0;
        end
      end
      default: begin
        state_d    = StLoad;
        overflow_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

  assign s_axis_tready   = (state_q == StLoad);
  assign m_axis_tvalid   = (state_q == StDrain) && slot[0].valid;
  assign m_axis_tdata    = slot[0].value;
  assign m_axis_tlast    = tail_empty;
  assign m_axis_tuser[0] = overflow_q;

  // Load and drain never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output active together");

  // Occupied cells form a contiguous run from cell 0.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("chain has a gap");

  // Final output beat returns the block to loading with a clear drop flag.
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && m_axis_tlast) |=> (s_axis_tready && !overflow_q))
    else $error("block not reopened after set");

  // A beat taken while full raises the drop flag.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && full) |=> overflow_q)
    else $error("drop not flagged");

endmodule

// ===== dv/insertion_sort_engine_core_test.sv =====
`timescale 1ns / 1ps

module insertion_sort_engine_core_test;

  import ise_pkg::*;

  typedef struct packed {
    logic signed [ValueW-1:0] sorted_value;
    logic                     end_of_set;
    logic                     dropped;
  } sorted_beat_t;

  // Track the sorted store and queue the ordered set that each closing beat releases.
  class sort_tracker;
    logic signed [ValueW-1:0] held [Capacity];
    int unsigned              held_n;
    bit                       overflow;
    sorted_beat_t             pending_order [$];
    int unsigned              errors;
    int unsigned              results_seen;

    function void note_value(logic signed [ValueW-1:0] v, logic is_last);
      int unsigned  pos;
      sorted_beat_t b;
      pos = held_n;
      if (pos >= Capacity) begin
        overflow = 1'b1;
      end else begin
        // Shift strictly greater entries up; equal ones stay ahead.
        while (pos > 0 && held[pos-1] > v) begin
          held[pos] = held[pos-1];
          pos--;
        end
        held[pos] = v;
        held_n++;
      end
      if (is_last) begin
        for (int unsigned k = 0; k < held_n; k++) begin
          b.sorted_value = held[k];
          b.end_of_set   = (k + 1 == held_n);
          b.dropped      = overflow;
          pending_order.push_back(b);
        end
        held_n   = 0;
        overflow = 1'b0;
      end
    endfunction

    function void check_result(logic signed [ValueW-1:0] got_value, logic got_last,
                               logic got_drop);
      sorted_beat_t want;
      results_seen++;
      if (pending_order.size() == 0) begin
        $error("unexpected result: sorted_value %0d end_of_set %0b dropped %0b",
               got_value, got_last, got_drop);
        errors++;
        return;
      end
      want = pending_order.pop_front();
      if (got_value !== want.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", want.sorted_value, got_value);
        errors++;
      end
      if (got_last !== want.end_of_set) begin
        $error("end_of_set: expected %0b, got %0b", want.end_of_set, got_last);
        errors++;
      end
      if (got_drop !== want.dropped) begin
        $error("dropped: expected %0b, got %0b", want.dropped, got_drop);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  sort_tracker book = new();
  bit          calm = 1'b0;
  bit          held_off = 1'b0;

  insertion_sort_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Offer one beat, hold it until taken, then maybe leave a gap.
  // Sample tready mid-cycle so the accepting edge is known before it happens.
  task automatic send_beat(input logic [31:0] v, input logic is_last);
    logic taken;
    s_axis_tdata  <= v;
    s_axis_tlast  <= is_last;
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    book.note_value(v, is_last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic send_set(input logic [31:0] vals [$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'($urandom_range(0, 15)) - 32'd8;
      1:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
      2:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  // Check every result beat that the coming rising edge accepts; sample mid-cycle
  // where handshake and data are settled.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      book.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end
  end

  // Sink: random stalls, plus one long hold-off so a drain backs up into the input.
  initial begin : sink
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held_off && m_axis_tvalid && book.results_seen >= 20) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin : source
    logic [31:0] vals [$];
    int unsigned sent;
    int unsigned set_idx;
    int unsigned n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets: single value, field extremes, duplicates, descending run.
    vals = '{32'd7};
    send_set(vals);
    vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd1};
    send_set(vals);
    vals = '{32'd5, 32'd5, -32'd5, 32'd5, -32'd5};
    send_set(vals);
    vals = '{32'd3, 32'd2, 32'd1, 32'd0, -32'd1, -32'd2};
    send_set(vals);
    vals = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_set(vals);

    // Random sets; a few fill the store exactly or overflow it.
    sent    = 0;
    set_idx = 0;
    while (sent < 225) begin
      case (set_idx)
        1:       n = Capacity;
        4:       n = Capacity + 1;
        7:       n = Capacity + 3;
        default: n = $urandom_range(1, 10);
      endcase
      vals.delete();
      repeat (n) vals.push_back(pick_value());
      send_set(vals);
      sent += n;
      set_idx++;
      if (sent >= 180) calm = 1'b1;
    end
    s_axis_tvalid <= 1'b0;

    while (book.pending_order.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("** insertion_sort_engine_core: PASSED **");
    end else begin
      $display("** insertion_sort_engine_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("** insertion_sort_engine_core: FAILED **");
    $finish;
  end

endmodule
